// ===== sv/c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants and the arctangent table for the Cartesian-to-polar
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

   // default configuration
   localparam int unsigned DEF_COMPONENT_WIDTH = 16;
   localparam int unsigned DEF_ROTATION_STAGES = 16;

   // fixed-point formats
   localparam int unsigned GUARD_BITS = 8;
   localparam int unsigned TURN_W     = 32;
   localparam int unsigned MAG_W      = 16;
   localparam int unsigned ANGLE_W    = 16;

   // half a turn in the 32-bit angle accumulator
   localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

   // 1/K in Q0.32 for the converged rotation gain
   localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;

   // atan(2^-i) as a fraction of one turn, 2^32 = full turn
   function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
      logic [TURN_W-1:0] r;
      unique case (idx)
         5'd0:  r = 32'h2000_0000;
         5'd1:  r = 32'h12E4_051E;
         5'd2:  r = 32'h09FB_385B;
         5'd3:  r = 32'h0511_11D4;
         5'd4:  r = 32'h028B_0D43;
         5'd5:  r = 32'h0145_D7E1;
         5'd6:  r = 32'h00A2_F61E;
         5'd7:  r = 32'h0051_7C55;
         5'd8:  r = 32'h0028_BE53;
         5'd9:  r = 32'h0014_5F2F;
         5'd10: r = 32'h000A_2F98;
         5'd11: r = 32'h0005_17CC;
         5'd12: r = 32'h0002_8BE6;
         5'd13: r = 32'h0001_45F3;
         5'd14: r = 32'h0000_A2FA;
         5'd15: r = 32'h0000_517D;
         5'd16: r = 32'h0000_28BE;
         5'd17: r = 32'h0000_145F;
         5'd18: r = 32'h0000_0A30;
         5'd19: r = 32'h0000_0518;
         5'd20: r = 32'h0000_028C;
         5'd21: r = 32'h0000_0146;
         5'd22: r = 32'h0000_00A3;
         5'd23: r = 32'h0000_0051;
         5'd24: r = 32'h0000_0029;
         5'd25: r = 32'h0000_0014;
         5'd26: r = 32'h0000_000A;
         5'd27: r = 32'h0000_0005;
         5'd28: r = 32'h0000_0003;
         5'd29: r = 32'h0000_0001;
         5'd30: r = 32'h0000_0001;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/cartesian_to_polar.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Pipelined vectoring converter from a signed (x, y) vector to its rounded
// length and its direction as an unsigned binary angle (65536 = full turn).
// ----------------------------------------------------------------------------
// Accepts one vector per clock while the output is not stalled and returns
// one result per vector, in order. The pipeline has one fold stage (left
// half plane is mirrored and the angle starts at a half turn), one register
// stage per micro-rotation, one stage for the two gain-compensation partial
// products and one output stage that rounds and saturates. Each stage holds
// its data while the next one is full and blocked, so a stall on rsp_stall
// holds every full stage up to the first empty one, and empty stages are
// filled while the output waits. The zero vector returns length 0 and angle 0.
`default_nettype none

module cartesian_to_polar
   import c2p_pkg::*;
#(
   parameter int unsigned COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
   parameter int unsigned ROTATION_STAGES = DEF_ROTATION_STAGES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_y,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [MAG_W-1:0]           rsp_magnitude,
   output logic        [ANGLE_W-1:0]         rsp_angle
);

   // datapath widths
   localparam int unsigned DW   = COMPONENT_WIDTH + GUARD_BITS + 3;
   localparam int unsigned UXW  = DW - 1;
   localparam int unsigned HIW  = UXW - 16 + 32;
   localparam int unsigned MW   = (DW + 17 > 41) ? DW + 17 : 41;
   localparam int unsigned R    = ROTATION_STAGES;
   localparam int unsigned NS   = R + 3;
   localparam int unsigned MULS = R + 1;
   localparam int unsigned OUTS = R + 2;
   localparam logic [MW-1:0] MAG_ROUND = MW'(64'd1) << (15 + GUARD_BITS);

   // per-stage valid bits and advance enables
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] adv;

   // rotation pipeline registers, index 0 is the fold stage
   logic signed [DW-1:0]     x_ff    [0:R];
   logic signed [DW-1:0]     x_in    [0:R];
   logic signed [DW-1:0]     y_ff    [0:R];
   logic signed [DW-1:0]     y_in    [0:R];
   logic        [TURN_W-1:0] z_ff    [0:R];
   logic        [TURN_W-1:0] z_in    [0:R];
   logic                     zero_ff [0:R];
   logic                     zero_in [0:R];

   // gain stage registers
   logic [HIW-1:0]     hi_ff,    hi_in;
   logic [31:0]        lo_ff,    lo_in;
   logic [ANGLE_W-1:0] ang_ff,   ang_in;
   logic               zmul_ff,  zmul_in;

   // output registers
   logic [MAG_W-1:0]   mag_ff,   mag_in;
   logic [ANGLE_W-1:0] angle_ff, angle_in;

   // a stage moves forward when it is empty or the stage after it moves
   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   // valid bits travel with the data
   always_comb begin
      valid_in[0] = req_valid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // fold stage: scale, mirror the left half plane, flag the zero vector
   logic signed [DW-1:0] x_scaled;
   logic signed [DW-1:0] y_scaled;
   logic                 x_negative;

   always_comb begin
      x_scaled   = DW'(req_vec_x) <<< GUARD_BITS;
      y_scaled   = DW'(req_vec_y) <<< GUARD_BITS;
      x_negative = req_vec_x[COMPONENT_WIDTH-1];
      zero_in[0] = (req_vec_x == '0) && (req_vec_y == '0);
      if (x_negative) begin
         x_in[0] = -x_scaled;
         y_in[0] = -y_scaled;
         z_in[0] = HALF_TURN;
      end else begin
         x_in[0] = x_scaled;
         y_in[0] = y_scaled;
         z_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         z_ff[0]    <= z_in[0];
         zero_ff[0] <= zero_in[0];
      end
   end

   // micro-rotation stages, each drives y toward zero
   for (genvar k = 1; k <= R; k++) begin : g_rot
      localparam int unsigned SHIFT = k - 1;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;

      always_comb begin
         dx = y_ff[k-1] >>> SHIFT;
         dy = x_ff[k-1] >>> SHIFT;
         zero_in[k] = zero_ff[k-1];
         if (y_ff[k-1][DW-1]) begin
            x_in[k] = x_ff[k-1] - dx;
            y_in[k] = y_ff[k-1] + dy;
            z_in[k] = z_ff[k-1] - atan_turn(5'(SHIFT));
         end else begin
            x_in[k] = x_ff[k-1] + dx;
            y_in[k] = y_ff[k-1] - dy;
            z_in[k] = z_ff[k-1] + atan_turn(5'(SHIFT));
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
   end

   // gain stage: two partial products of x and the inverse gain
   logic [UXW-1:0] ux;

   always_comb begin
      ux      = x_ff[R][DW-1] ? '0 : x_ff[R][UXW-1:0];
      hi_in   = HIW'(ux[UXW-1:16]) * HIW'(INV_GAIN_Q32);
      lo_in   = 32'((48'(ux[15:0]) * 48'(INV_GAIN_Q32)) >> 16);
      ang_in  = 16'((z_ff[R] + TURN_W'(32'h0000_8000)) >> 16);
      zmul_in = zero_ff[R];
   end

   always_ff @(posedge clock) begin
      if (adv[MULS]) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         ang_ff  <= ang_in;
         zmul_ff <= zmul_in;
      end
   end

   // output stage: sum, round, saturate
   logic [MW-1:0] msum;
   logic [MW-1:0] mrnd;

   always_comb begin
      msum = MW'(hi_ff) + MW'(lo_ff);
      mrnd = (msum + MAG_ROUND) >> (16 + GUARD_BITS);
      if (zmul_ff) begin
         mag_in   = '0;
         angle_in = '0;
      end else begin
         mag_in   = (mrnd[MW-1:MAG_W] != '0) ? '1 : mrnd[MAG_W-1:0];
         angle_in = ang_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OUTS]) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = valid_ff[OUTS];
   assign rsp_magnitude = mag_ff;
   assign rsp_angle     = angle_ff;

   // after the fold x is never negative
   a_fold_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> !x_ff[0][DW-1])
      else $error("fold stage holds a negative x");

   // an empty fold stage always takes a transaction
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("request stalled with empty fold stage");

   // zero vector comes out as zero length and zero angle
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (adv[OUTS] && valid_ff[MULS] && zmul_ff) |=>
         (rsp_magnitude == '0 && rsp_angle == '0))
      else $error("zero vector gave a nonzero result");

   // a blocked last rotation stage keeps its angle
   a_rot_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[R] && !adv[R]) |=> (valid_ff[R] && $stable(z_ff[R])))
      else $error("blocked rotation stage lost its transaction");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
